[rtl/dsht_pkg.sv]
package dsht_pkg;

    localparam int WAYS     = 4;
    localparam int BUCKETS  = 65536;
    localparam int BUCKET_W = 16;
    localparam int KEY_W    = 64;
    localparam int SIZE_W   = 32;
    localparam int ID_W     = 16;
    localparam int FILL_W   = $clog2(WAYS + 1);

    localparam logic [BUCKET_W-1:0] HASH_MUL0 = BUCKET_W'(211);
    localparam logic [BUCKET_W-1:0] HASH_MUL1 = BUCKET_W'(37);

    typedef struct packed {
        logic [KEY_W-1:0]  key_high;
        logic [KEY_W-1:0]  key_low;
        logic [SIZE_W-1:0] file_size;
        logic [ID_W-1:0]   entry_id;
    } slot_t;

    // one memory row holds a whole bucket: fill count and its slots
    typedef struct packed {
        logic [FILL_W-1:0]      fill;
        slot_t [WAYS-1:0]       slots;
    } row_t;

    localparam int ROW_W  = $bits(row_t);

    typedef enum logic [1:0] {
        ST_CLEAN  = 2'd0,
        ST_MATCH  = 2'd1,
        ST_STORED = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } state_t;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // 211*b0 + 37*b1 + b2 over the top three digest bytes; max 63495
    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [KEY_W-1:0] kh);
        logic [BUCKET_W-1:0] b0;
        logic [BUCKET_W-1:0] b1;
        logic [BUCKET_W-1:0] b2;
        b0 = {8'd0, kh[63:56]};
        b1 = {8'd0, kh[55:48]};
        b2 = {8'd0, kh[47:40]};
        return b0 * HASH_MUL0 + b1 * HASH_MUL1 + b2;
    endfunction

endpackage

[rtl/dsht_ram.sv]
module dsht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/dsht_match.sv]
module dsht_match
    import dsht_pkg::*;
(
    input  row_t              row,
    input  logic [KEY_W-1:0]  key_high,
    input  logic [KEY_W-1:0]  key_low,
    input  logic [SIZE_W-1:0] file_size,
    output logic              hit,
    output logic [ID_W-1:0]   hit_id
);

    // later ways are newer, so the last match below the fill count wins
    always_comb
    begin
        hit    = 1'b0;
        hit_id = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (FILL_W'(w) < row.fill &&
                row.slots[w].key_high == key_high &&
                row.slots[w].key_low == key_low &&
                row.slots[w].file_size == file_size)
            begin
                hit    = 1'b1;
                hit_id = row.slots[w].entry_id;
            end
        end
    end

endmodule

[rtl/digest_signature_hash_table.sv]
// channel | handshake            | dir | word
// in      | in_valid, in_ready   | in  | kind, key_high, key_low, file_size, entry_id
// out     | out_valid, out_ready | out | status, match_id
//
// Each word passes accept (bucket row read issued), then evaluate (compare,
// write back on insert, result into the output register); the registered
// row read sets this, and no new word is taken until evaluate is done, which
// waits while the output register is still held. After reset a clearing pass
// zeroes all 65536 bucket rows, one per cycle; in_ready stays low for those cycles.
module digest_signature_hash_table_core
    import dsht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [KEY_W-1:0]  key_high,
    input  logic [KEY_W-1:0]  key_low,
    input  logic [SIZE_W-1:0] file_size,
    input  logic [ID_W-1:0]   entry_id,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [ID_W-1:0]   match_id
);

    state_t state_reg;
    state_t state_next;

    logic [BUCKET_W-1:0] clr_cnt_reg;
    logic [BUCKET_W-1:0] clr_cnt_next;

    logic                kind_reg;
    logic [KEY_W-1:0]    key_high_reg;
    logic [KEY_W-1:0]    key_low_reg;
    logic [SIZE_W-1:0]   file_size_reg;
    logic [ID_W-1:0]     entry_id_reg;
    logic [BUCKET_W-1:0] bucket_reg;

    logic      out_valid_reg;
    status_t   status_reg;
    logic [ID_W-1:0] match_id_reg;

    logic                ram_wr_en;
    logic [BUCKET_W-1:0] ram_wr_addr;
    logic [ROW_W-1:0]    ram_wr_data;
    logic                ram_rd_en;
    logic [BUCKET_W-1:0] ram_rd_addr;
    logic [ROW_W-1:0]    ram_rd_data;

    row_t            rd_row;
    row_t            new_row;
    logic            bucket_full;
    logic            hit;
    logic [ID_W-1:0] hit_id;
    logic            accept;
    logic            go;
    status_t         result_status;
    logic [ID_W-1:0] result_id;

    dsht_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_rows (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_row = row_t'(ram_rd_data);

    dsht_match u_match (
        .row       (rd_row),
        .key_high  (key_high_reg),
        .key_low   (key_low_reg),
        .file_size (file_size_reg),
        .hit       (hit),
        .hit_id    (hit_id)
    );

    assign accept      = (state_reg == S_IDLE) && in_valid;
    assign go          = (state_reg == S_EVAL) && (!out_valid_reg || out_ready);
    assign bucket_full = (rd_row.fill >= FILL_W'(WAYS));

    // append the new slot at the fill position
    always_comb
    begin
        new_row      = rd_row;
        new_row.fill = rd_row.fill + FILL_W'(1);
        for (int w = 0; w < WAYS; w++)
        begin
            if (FILL_W'(w) == rd_row.fill)
            begin
                new_row.slots[w].key_high  = key_high_reg;
                new_row.slots[w].key_low   = key_low_reg;
                new_row.slots[w].file_size = file_size_reg;
                new_row.slots[w].entry_id  = entry_id_reg;
            end
        end
    end

    always_comb
    begin
        if (kind_reg == KIND_INSERT)
        begin
            result_status = bucket_full ? ST_FULL : ST_STORED;
            result_id     = '0;
        end
        else
        begin
            result_status = hit ? ST_MATCH : ST_CLEAN;
            result_id     = hit ? hit_id : '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == BUCKET_W'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // outputs and memory control
    always_comb
    begin
        in_ready     = 1'b0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = bucket_of(key_high);
        ram_wr_en    = 1'b0;
        ram_wr_addr  = bucket_reg;
        ram_wr_data  = ROW_W'(new_row);
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + BUCKET_W'(1);
            end
            S_IDLE:
            begin
                in_ready  = 1'b1;
                ram_rd_en = in_valid;
            end
            S_EVAL:
            begin
                ram_wr_en = go && (kind_reg == KIND_INSERT) && !bucket_full;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= kind;
            key_high_reg  <= key_high;
            key_low_reg   <= key_low;
            file_size_reg <= file_size;
            entry_id_reg  <= entry_id;
            bucket_reg    <= bucket_of(key_high);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            status_reg   <= result_status;
            match_id_reg <= result_id;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign match_id  = match_id_reg;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import dsht_pkg::*;

    localparam int N_DIR      = 21;
    localparam int N_RAND     = 850;
    localparam int QUIET_TAIL = 120;
    localparam int HOLD_OFF   = 300;
    localparam int LIMIT      = 400000;

    typedef struct {
        logic              kind;
        logic [KEY_W-1:0]  kh;
        logic [KEY_W-1:0]  kl;
        logic [SIZE_W-1:0] fsize;
        logic [ID_W-1:0]   id;
    } word_t;

    typedef struct {
        status_t         st;
        logic [ID_W-1:0] mid;
    } verdict_t;

    typedef struct {
        word_t    w;
        logic     typed;
        verdict_t v;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              kind = 1'b0;
    logic [KEY_W-1:0]  key_high = '0;
    logic [KEY_W-1:0]  key_low = '0;
    logic [SIZE_W-1:0] file_size = '0;
    logic [ID_W-1:0]   entry_id = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        status;
    logic [ID_W-1:0]   match_id;

    // shadow of the bucket table
    int        fill_count [int];
    slot_t     slot_store [int];
    verdict_t  verdict_q [$];
    word_t     sig_hist [$];
    logic [23:0] prefix_pool [$];

    int  errors = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    bit  quiet_tail = 1'b0;
    bit  idle_on = 1'b1;
    verdict_t due;

    localparam logic [63:0] ONES = '1;
    // both prefixes hash to bucket 37: (0,0,37) and (0,1,0)
    localparam logic [63:0] KA = 64'h0000_2501_2345_6789;
    localparam logic [63:0] KB = 64'h0001_00ab_cdef_0123;
    localparam logic [63:0] KC = 64'h0000_2500_0000_0000;
    localparam logic [63:0] KD = 64'h0001_0000_0000_0001;

    dir_row_t dir_rows [N_DIR] = '{
        // lookups on an empty table
        '{'{KIND_LOOKUP, 64'h0, 64'h0, 32'h0, 16'h0}, 1'b1, '{ST_CLEAN, 16'h0}},
        '{'{KIND_LOOKUP, ONES, ONES, 32'hffff_ffff, 16'hffff}, 1'b1, '{ST_CLEAN, 16'h0}},
        // extremes stored and found again
        '{'{KIND_INSERT, 64'h0, 64'h0, 32'h0, 16'h0}, 1'b1, '{ST_STORED, 16'h0}},
        '{'{KIND_INSERT, ONES, ONES, 32'hffff_ffff, 16'hffff}, 1'b1, '{ST_STORED, 16'h0}},
        '{'{KIND_LOOKUP, 64'h0, 64'h0, 32'h0, 16'hffff}, 1'b1, '{ST_MATCH, 16'h0}},
        '{'{KIND_LOOKUP, ONES, ONES, 32'hffff_ffff, 16'h0}, 1'b1, '{ST_MATCH, 16'hffff}},
        // near misses: size, low digest, low bit of high digest
        '{'{KIND_LOOKUP, ONES, ONES, 32'hffff_fffe, 16'h0}, 1'b1, '{ST_CLEAN, 16'h0}},
        '{'{KIND_LOOKUP, ONES, 64'hffff_ffff_ffff_fffe, 32'hffff_ffff, 16'h0}, 1'b1,
          '{ST_CLEAN, 16'h0}},
        '{'{KIND_LOOKUP, 64'hffff_ffff_ffff_fffe, ONES, 32'hffff_ffff, 16'h0}, 1'b1,
          '{ST_CLEAN, 16'h0}},
        // fill bucket 37 from two colliding prefixes, with a duplicate
        '{'{KIND_INSERT, KA, 64'h1111, 32'd100, 16'd1}, 1'b1, '{ST_STORED, 16'h0}},
        '{'{KIND_INSERT, KB, 64'h2222, 32'd200, 16'd2}, 1'b1, '{ST_STORED, 16'h0}},
        '{'{KIND_INSERT, KA, 64'h1111, 32'd100, 16'd3}, 1'b1, '{ST_STORED, 16'h0}},
        '{'{KIND_INSERT, KC, 64'h0, 32'd0, 16'd4}, 1'b1, '{ST_STORED, 16'h0}},
        '{'{KIND_INSERT, KD, 64'h5, 32'd5, 16'd5}, 1'b1, '{ST_FULL, 16'h0}},
        '{'{KIND_LOOKUP, KA, 64'h1111, 32'd100, 16'h0}, 1'b0, '{ST_CLEAN, 16'h0}},
        '{'{KIND_LOOKUP, KB, 64'h2222, 32'd200, 16'h0}, 1'b0, '{ST_CLEAN, 16'h0}},
        '{'{KIND_LOOKUP, KD, 64'h5, 32'd5, 16'h0}, 1'b0, '{ST_CLEAN, 16'h0}},
        '{'{KIND_LOOKUP, KA, 64'h1111, 32'd101, 16'h0}, 1'b0, '{ST_CLEAN, 16'h0}},
        '{'{KIND_LOOKUP, KC, 64'h0, 32'd0, 16'h0}, 1'b0, '{ST_CLEAN, 16'h0}},
        // duplicate of the all-zero signature, newest wins
        '{'{KIND_INSERT, 64'h0, 64'h0, 32'h0, 16'd7}, 1'b0, '{ST_CLEAN, 16'h0}},
        '{'{KIND_LOOKUP, 64'h0, 64'h0, 32'h0, 16'h0}, 1'b0, '{ST_CLEAN, 16'h0}}
    };

    digest_signature_hash_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .key_high  (key_high),
        .key_low   (key_low),
        .file_size (file_size),
        .entry_id  (entry_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .match_id  (match_id)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // updates the shadow table and returns the verdict the block owes
    function automatic verdict_t predict_verdict(input word_t w);
        verdict_t v;
        int bkt;
        int fill;
        bit found;
        slot_t s;
        bkt = 211 * int'(w.kh[63:56]) + 37 * int'(w.kh[55:48]) + int'(w.kh[47:40]);
        fill = fill_count.exists(bkt) ? fill_count[bkt] : 0;
        v.st = ST_CLEAN;
        v.mid = '0;
        found = 1'b0;
        if (w.kind == KIND_INSERT)
        begin
            if (fill >= WAYS)
                v.st = ST_FULL;
            else
            begin
                s.key_high = w.kh;
                s.key_low = w.kl;
                s.file_size = w.fsize;
                s.entry_id = w.id;
                slot_store[bkt * WAYS + fill] = s;
                fill_count[bkt] = fill + 1;
                v.st = ST_STORED;
            end
        end
        else
        begin
            for (int k = fill - 1; k >= 0; k--)
            begin
                s = slot_store[bkt * WAYS + k];
                if (!found && s.key_high == w.kh && s.key_low == w.kl
                    && s.file_size == w.fsize)
                begin
                    found = 1'b1;
                    v.st = ST_MATCH;
                    v.mid = s.entry_id;
                end
            end
        end
        return v;
    endfunction

    // random word aimed at a small set of buckets, with hits from the history
    function automatic word_t random_word();
        word_t w;
        int pick;
        int k;
        w.kind = 1'($urandom_range(0, 1));
        w.kl = {$urandom, $urandom};
        w.fsize = $urandom;
        w.id = 16'($urandom);
        if ($urandom_range(0, 9) < 3)
            w.kh = {$urandom, $urandom};
        else
            w.kh = {prefix_pool[$urandom_range(0, prefix_pool.size() - 1)],
                    40'({$urandom, $urandom})};
        if (sig_hist.size() != 0)
        begin
            pick = $urandom_range(0, 9);
            if ((w.kind == KIND_LOOKUP && pick < 8) || (w.kind == KIND_INSERT && pick == 0))
            begin
                k = $urandom_range(0, sig_hist.size() - 1);
                w.kh = sig_hist[k].kh;
                w.kl = sig_hist[k].kl;
                w.fsize = sig_hist[k].fsize;
                if (w.kind == KIND_LOOKUP && pick >= 6)
                begin
                    case ($urandom_range(0, 2))
                        0: begin k = $urandom_range(0, 63); w.kl[k] = ~w.kl[k]; end
                        1: begin k = $urandom_range(0, 31); w.fsize[k] = ~w.fsize[k]; end
                        default: begin k = $urandom_range(0, 39); w.kh[k] = ~w.kh[k]; end
                    endcase
                end
            end
        end
        if (w.kind == KIND_INSERT)
            sig_hist.push_back(w);
        return w;
    endfunction

    task automatic send_word(input word_t w, input logic typed, input verdict_t typed_v);
        verdict_t v;
        if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= w.kind;
        key_high <= w.kh;
        key_low <= w.kl;
        file_size <= w.fsize;
        entry_id <= w.id;
        do
            @(posedge clk);
        while (!in_ready);
        v = predict_verdict(w);
        if (typed)
            v = typed_v;
        verdict_q.push_back(v);
    endtask

    // receiver: random stall bursts, one long hold-off to back the block up
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= 60)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!quiet_tail && idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (verdict_q.size() == 0)
            begin
                $error("unexpected result word: status %0d match_id %0d", status, match_id);
                errors++;
            end
            else
            begin
                due = verdict_q.pop_front();
                if (status !== due.st)
                begin
                    $error("status: expected %0d, got %0d", due.st, status);
                    errors++;
                end
                if (match_id !== due.mid)
                begin
                    $error("match_id: expected %0d, got %0d", due.mid, match_id);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        verdict_t none;
        none.st = ST_CLEAN;
        none.mid = '0;
        // prefix pairs that collide: (b0, b1, b2) and (b0, b1-1, b2+37)
        for (int i = 0; i < 40; i++)
        begin
            b0 = 8'($urandom_range(0, 255));
            b1 = 8'($urandom_range(1, 255));
            b2 = 8'($urandom_range(0, 218));
            prefix_pool.push_back({b0, b1, b2});
            prefix_pool.push_back({b0, b1 - 8'd1, b2 + 8'd37});
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_rows[i].w.kind == KIND_INSERT)
                sig_hist.push_back(dir_rows[i].w);
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].v);
        end

        for (int i = 0; i < N_RAND; i++)
        begin
            if (i % 60 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (i >= N_RAND - QUIET_TAIL)
                quiet_tail = 1'b1;
            send_word(random_word(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
